// File: src/irmsct_pkg.sv
// ----------------------------------------------------------------------------
// irmsct_pkg
// Shared constants for the infrared mark/space carrier transmitter: field
// widths, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package irmsct_pkg;

    // Payload field widths
    localparam int DUR_W        = 16;
    localparam int CARRIER_W    = 12;
    localparam int CFG_DATA_W   = 12;
    localparam int CFG_IDX_W    = 2;

    // Default depth of the duration counter
    localparam int DURATION_BITS_DEF = 16;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CARRIER_ON  = 2'd0,
        CFG_CARRIER_OFF = 2'd1,
        CFG_ACTIVE_HIGH = 2'd2
    } cfg_index_t;

    // Configuration reset values
    localparam logic [CARRIER_W-1:0] CARRIER_ON_RST  = 12'd13;
    localparam logic [CARRIER_W-1:0] CARRIER_OFF_RST = 12'd13;
    localparam logic                 ACTIVE_HIGH_RST = 1'b1;

endpackage

// File: src/ir_mark_space_carrier_transmitter_unit.sv
// ----------------------------------------------------------------------------
// ir_mark_space_carrier_transmitter_unit
// Drives one infrared pin from host-loaded mark/space durations, chopping
// marks with a soft carrier. One input transfer is one microsecond tick or
// one entry load; each gives exactly one status transfer.
//
//   channel  | signals                                        | direction
//   ---------+------------------------------------------------+----------
//   in       | in_valid, in_stall, mode, duration_us,         | host -> unit
//            | last_entry, abort_req                          |
//   out      | out_valid, out_stall, pin_level, need_entry,   | unit -> host
//            | frame_done, load_rejected                      |
//   cfg      | cfg_we, cfg_index, cfg_data                    | host -> unit
//
// Each input transfer is handled at the edge that accepts it: the frame state
// registers and the result register update together, so one transfer per clock
// is sustained while in_stall is low. The result appears in the next cycle.
// in_stall rises only while a result is held and out_stall is high.
// Reset returns the unit to idle with the default carrier of 13/13 us and an
// active-high pin.
// ----------------------------------------------------------------------------
module ir_mark_space_carrier_transmitter_unit
    import irmsct_pkg::*;
#(
    parameter int DURATION_BITS = DURATION_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  mode,
    input  logic [DUR_W-1:0]      duration_us,
    input  logic                  last_entry,
    input  logic                  abort_req,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  pin_level,
    output logic                  need_entry,
    output logic                  frame_done,
    output logic                  load_rejected,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DB = DURATION_BITS;

    // Configuration registers
    logic [CARRIER_W-1:0] carrier_on_reg;
    logic [CARRIER_W-1:0] carrier_off_reg;
    logic                 active_high_reg;

    // Frame state
    logic                 busy_reg,       busy_next;
    logic                 is_space_reg,   is_space_next;
    logic [DB-1:0]        remaining_reg,  remaining_next;
    logic                 phase_on_reg,   phase_on_next;
    logic [CARRIER_W-1:0] seg_left_reg,   seg_left_next;
    logic                 final_reg,      final_next;

    // Result register
    logic out_valid_reg;
    logic pin_reg,  pin_next;
    logic need_reg, need_next;
    logic done_reg, done_next;
    logic rej_reg,  rej_next;

    logic                 accept;
    logic                 carrier_en;
    logic                 active;
    logic [DB-1:0]        load_dur;
    logic [DB-1:0]        rem_dec;
    logic [CARRIER_W-1:0] seg_load;
    logic [CARRIER_W-1:0] seg_dec;
    logic                 entry_end;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    assign carrier_en = (carrier_on_reg != '0) && (carrier_off_reg != '0);

    // Saturate the loaded duration to the counter depth
    generate
        if (DB >= DUR_W) begin : g_dur_wide
            assign load_dur = DB'(duration_us);
        end
        else begin : g_dur_narrow
            assign load_dur = (|duration_us[DUR_W-1:DB]) ? '1 : duration_us[DB-1:0];
        end
    endgenerate

    // Carrier segment arithmetic for a tick inside a chopped mark
    assign seg_load = (seg_left_reg != '0) ? seg_left_reg
                    : (phase_on_reg ? carrier_on_reg : carrier_off_reg);
    assign seg_dec  = seg_load - 1'b1;
    assign rem_dec  = remaining_reg - 1'b1;

    // Work out the next frame state and the result of one transfer
    always_comb
    begin
        busy_next      = busy_reg;
        is_space_next  = is_space_reg;
        remaining_next = remaining_reg;
        phase_on_next  = phase_on_reg;
        seg_left_next  = seg_left_reg;
        final_next     = final_reg;
        active         = 1'b0;
        need_next      = 1'b0;
        done_next      = 1'b0;
        rej_next       = 1'b0;
        entry_end      = 1'b0;

        priority if (abort_req)
        begin
            busy_next      = 1'b0;
            is_space_next  = 1'b0;
            remaining_next = '0;
            phase_on_next  = 1'b0;
            seg_left_next  = '0;
            final_next     = 1'b0;
            done_next      = 1'b1;
        end
        else if (mode)
        begin
            if (busy_reg)
            begin
                // Reject the load, show the running level without advancing
                rej_next = 1'b1;
                active   = !is_space_reg && (!carrier_en || phase_on_reg);
            end
            else
            begin
                remaining_next = load_dur;
                final_next     = last_entry;
                busy_next      = 1'b1;
                entry_end      = (load_dur == '0);
            end
        end
        else if (busy_reg)
        begin
            remaining_next = rem_dec;
            entry_end      = (rem_dec == '0);
            if (is_space_reg)
            begin
                active = 1'b0;
            end
            else if (!carrier_en)
            begin
                active = 1'b1;
            end
            else
            begin
                active = phase_on_reg;
                if ((seg_dec == '0) || (rem_dec == '0))
                begin
                    phase_on_next = !phase_on_reg;
                    seg_left_next = '0;
                end
                else
                begin
                    seg_left_next = seg_dec;
                end
            end
        end
        else
        begin
            // Idle tick: hold everything, pin inactive
            active = 1'b0;
        end

        // Finish the entry: end the frame or ask for the next entry
        if (entry_end)
        begin
            if (final_next)
            begin
                busy_next      = 1'b0;
                is_space_next  = 1'b0;
                remaining_next = '0;
                phase_on_next  = 1'b0;
                seg_left_next  = '0;
                final_next     = 1'b0;
                done_next      = 1'b1;
            end
            else
            begin
                busy_next      = 1'b0;
                is_space_next  = !is_space_reg;
                remaining_next = '0;
                need_next      = 1'b1;
            end
        end

        pin_next = active ^ !active_high_reg;
    end

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carrier_on_reg  <= CARRIER_ON_RST;
            carrier_off_reg <= CARRIER_OFF_RST;
            active_high_reg <= ACTIVE_HIGH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CARRIER_ON:  carrier_on_reg  <= cfg_data[CARRIER_W-1:0];
                CFG_CARRIER_OFF: carrier_off_reg <= cfg_data[CARRIER_W-1:0];
                CFG_ACTIVE_HIGH: active_high_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Advance frame state on each input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            is_space_reg  <= 1'b0;
            remaining_reg <= '0;
            phase_on_reg  <= 1'b0;
            seg_left_reg  <= '0;
            final_reg     <= 1'b0;
        end
        else if (accept)
        begin
            busy_reg      <= busy_next;
            is_space_reg  <= is_space_next;
            remaining_reg <= remaining_next;
            phase_on_reg  <= phase_on_next;
            seg_left_reg  <= seg_left_next;
            final_reg     <= final_next;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pin_reg  <= pin_next;
            need_reg <= need_next;
            done_reg <= done_next;
            rej_reg  <= rej_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pin_level     = pin_reg;
    assign need_entry    = need_reg;
    assign frame_done    = done_reg;
    assign load_rejected = rej_reg;

    // Checks on the frame logic
    a_busy_has_time: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (remaining_reg != '0))
        else $error("running entry with no time left");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(need_reg && done_reg) && !(rej_reg && (need_reg || done_reg)))
        else $error("conflicting status flags");

    a_abort_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && abort_req) |=> (!busy_reg && !final_reg && !phase_on_reg
                                    && done_reg && out_valid_reg))
        else $error("abort did not end the frame");

    a_reject_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !abort_req && mode && busy_reg) |=>
            ($stable(remaining_reg) && $stable(seg_left_reg) && busy_reg))
        else $error("rejected load changed the running entry");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && done_next) |=> (!busy_reg && !is_space_reg))
        else $error("frame end left state behind");

endmodule

// File: test/tb_ir_mark_space_carrier_transmitter_unit.sv
// ----------------------------------------------------------------------------
// tb_ir_mark_space_carrier_transmitter_unit
// Self-checking bench for the infrared mark/space carrier transmitter. A
// directed table of ticks, loads and aborts runs first. Phases of random
// frames follow, each under its own carrier and polarity setting. A local
// frame predictor computes the pin and flags for every accepted transfer,
// and the status channel is checked against it in order.
// ----------------------------------------------------------------------------
module tb_ir_mark_space_carrier_transmitter_unit;
    import irmsct_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_LOAD = 1'b1;
    localparam int   HOLD_CYCLES = 300;
    localparam int   LIMIT_CYCLES = 400000;

    typedef struct packed {
        logic pin_level;
        logic need_entry;
        logic frame_done;
        logic load_rejected;
    } ir_status_t;

    typedef struct packed {
        logic             mode;
        logic [DUR_W-1:0] duration_us;
        logic             last_entry;
        logic             abort_req;
        logic             fixed;
        ir_status_t       fixed_status;
    } ir_cmd_t;

    typedef struct packed {
        logic                 busy;
        logic                 is_space;
        logic [DUR_W-1:0]     remaining;
        logic                 phase_on;
        logic [CARRIER_W-1:0] seg_left;
        logic                 final_entry;
    } frame_t;

    typedef struct packed {
        logic [CARRIER_W-1:0] on_us;
        logic [CARRIER_W-1:0] off_us;
        logic                 hi;
        logic [7:0]           snd_pct;
        logic [7:0]           rcv_pct;
        logic [15:0]          n_items;
        logic                 hold;
    } phase_plan_t;

    localparam ir_status_t ST_QUIET = 4'b0000;
    localparam ir_status_t ST_NEED  = 4'b0100;
    localparam ir_status_t ST_DONE  = 4'b0010;
    localparam ir_status_t ST_REJ   = 4'b0001;

    // Directed frames under the reset carrier of 13/13 us, active high
    localparam ir_cmd_t DIRECTED [24] = '{
        '{MODE_TICK, 16'h0000, 1'b0, 1'b0, 1'b1, ST_QUIET}, // tick while idle
        '{MODE_TICK, 16'hFFFF, 1'b1, 1'b1, 1'b1, ST_DONE},  // abort while idle
        '{MODE_LOAD, 16'h0000, 1'b0, 1'b0, 1'b1, ST_NEED},  // zero-length mark
        '{MODE_LOAD, 16'h0000, 1'b1, 1'b0, 1'b1, ST_DONE},  // zero-length final space
        '{MODE_LOAD, 16'h0003, 1'b0, 1'b0, 1'b1, ST_QUIET}, // load while idle
        '{MODE_LOAD, 16'hFFFF, 1'b1, 1'b0, 1'b1, ST_REJ},   // load while busy
        '{MODE_TICK, 16'hA5A5, 1'b1, 1'b0, 1'b0, ST_QUIET},
        '{MODE_TICK, 16'h5A5A, 1'b0, 1'b0, 1'b0, ST_QUIET},
        '{MODE_TICK, 16'hFFFF, 1'b1, 1'b0, 1'b0, ST_QUIET},
        '{MODE_LOAD, 16'h0002, 1'b0, 1'b0, 1'b1, ST_QUIET}, // space entry
        '{MODE_TICK, 16'h0000, 1'b0, 1'b0, 1'b0, ST_QUIET},
        '{MODE_TICK, 16'h0000, 1'b0, 1'b0, 1'b0, ST_QUIET},
        '{MODE_LOAD, 16'hFFFF, 1'b0, 1'b0, 1'b1, ST_QUIET}, // longest mark
        '{MODE_TICK, 16'h1234, 1'b0, 1'b0, 1'b0, ST_QUIET},
        '{MODE_TICK, 16'h8000, 1'b1, 1'b0, 1'b0, ST_QUIET},
        '{MODE_LOAD, 16'h0000, 1'b1, 1'b1, 1'b1, ST_DONE},  // abort beats load
        '{MODE_LOAD, 16'h0001, 1'b1, 1'b0, 1'b1, ST_QUIET}, // one-tick final mark
        '{MODE_TICK, 16'h0000, 1'b0, 1'b0, 1'b0, ST_QUIET},
        '{MODE_TICK, 16'h0000, 1'b0, 1'b0, 1'b1, ST_QUIET}, // idle after frame end
        '{MODE_LOAD, 16'd30,   1'b0, 1'b0, 1'b1, ST_QUIET}, // mark left running
        '{MODE_TICK, 16'h0000, 1'b0, 1'b0, 1'b0, ST_QUIET},
        '{MODE_TICK, 16'h0000, 1'b0, 1'b0, 1'b0, ST_QUIET},
        '{MODE_TICK, 16'h0000, 1'b0, 1'b0, 1'b0, ST_QUIET},
        '{MODE_TICK, 16'h0000, 1'b0, 1'b0, 1'b0, ST_QUIET}
    };

    // Ticks left of the mark that the directed table leaves running
    localparam int DIRECTED_TAIL = 26;

    // Random phases: carrier on/off, polarity, idling, item count, long hold
    localparam phase_plan_t PLAN [6] = '{
        '{12'd1,    12'd1,    1'b0, 8'd24, 8'd52, 16'd180, 1'b0},
        '{12'd0,    12'd5,    1'b1, 8'd24, 8'd52, 16'd160, 1'b1},
        '{12'd4095, 12'd4095, 1'b0, 8'd52, 8'd24, 16'd160, 1'b0},
        '{12'd3,    12'd7,    1'b1, 8'd52, 8'd24, 16'd180, 1'b0},
        '{12'd9,    12'd0,    1'b0, 8'd0,  8'd0,  16'd160, 1'b1},
        '{12'd13,   12'd13,   1'b1, 8'd0,  8'd0,  16'd160, 1'b0}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  mode = 1'b0;
    logic [DUR_W-1:0]      duration_us = '0;
    logic                  last_entry = 1'b0;
    logic                  abort_req = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  pin_level;
    logic                  need_entry;
    logic                  frame_done;
    logic                  load_rejected;
    logic                  cfg_we = 1'b0;
    cfg_index_t            cfg_index = CFG_CARRIER_ON;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Local copy of the registers and the frame state
    logic [CARRIER_W-1:0] carrier_on_cfg = CARRIER_ON_RST;
    logic [CARRIER_W-1:0] carrier_off_cfg = CARRIER_OFF_RST;
    logic                 pol_high = ACTIVE_HIGH_RST;
    frame_t               frame = '0;

    ir_cmd_t    cmd_q[$];
    ir_status_t pending_status_q[$];

    int mismatches = 0;
    int cycles = 0;
    int snd_idle_pct = 24;
    int rcv_idle_pct = 52;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int gen_left = 0;

    ir_mark_space_carrier_transmitter_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .duration_us   (duration_us),
        .last_entry    (last_entry),
        .abort_req     (abort_req),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pin_level     (pin_level),
        .need_entry    (need_entry),
        .frame_done    (frame_done),
        .load_rejected (load_rejected),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic pin_for(input logic active);
        return pol_high ? active : !active;
    endfunction

    // Advance the frame by one transfer and return the pin and flags it gives
    function automatic ir_status_t predict_status(input ir_cmd_t c);
        ir_status_t st;
        logic       carrier_run;
        logic       entry_over;
        st = ST_QUIET;
        st.pin_level = pin_for(1'b0);
        carrier_run = (carrier_on_cfg != 0) && (carrier_off_cfg != 0);
        entry_over = 1'b0;
        if (c.abort_req)
        begin
            frame = '0;
            st.frame_done = 1'b1;
        end
        else if (c.mode == MODE_LOAD)
        begin
            if (frame.busy)
            begin
                // Rejected load: show the running level, advance nothing
                st.load_rejected = 1'b1;
                if (frame.is_space)
                    st.pin_level = pin_for(1'b0);
                else if (!carrier_run)
                    st.pin_level = pin_for(1'b1);
                else
                    st.pin_level = pin_for(frame.phase_on);
            end
            else
            begin
                frame.remaining = c.duration_us;
                frame.final_entry = c.last_entry;
                frame.busy = 1'b1;
                entry_over = (c.duration_us == 0);
            end
        end
        else if (frame.busy)
        begin
            frame.remaining = frame.remaining - 1'b1;
            if (frame.is_space)
                st.pin_level = pin_for(1'b0);
            else if (!carrier_run)
                st.pin_level = pin_for(1'b1);
            else
            begin
                // Chop the mark; a segment also ends with the entry
                if (frame.seg_left == 0)
                    frame.seg_left = frame.phase_on ? carrier_on_cfg : carrier_off_cfg;
                st.pin_level = pin_for(frame.phase_on);
                frame.seg_left = frame.seg_left - 1'b1;
                if (frame.seg_left == 0 || frame.remaining == 0)
                begin
                    frame.phase_on = !frame.phase_on;
                    frame.seg_left = '0;
                end
            end
            entry_over = (frame.remaining == 0);
        end
        if (entry_over)
        begin
            if (frame.final_entry)
            begin
                frame = '0;
                st.frame_done = 1'b1;
            end
            else
            begin
                frame.busy = 1'b0;
                frame.is_space = !frame.is_space;
                frame.remaining = '0;
                st.need_entry = 1'b1;
            end
        end
        return st;
    endfunction

    function automatic void check_field(input string name, input logic want, input logic got);
        if (got !== want)
        begin
            $error("%s: expected %0b, got %0b", name, want, got);
            mismatches++;
        end
    endfunction

    // Input side: predict at each transfer, hold while stalled, idle at random
    always @(posedge clk)
    begin : sender
        ir_cmd_t cur;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                cur = '{mode, duration_us, last_entry, abort_req, cur.fixed,
                        cur.fixed_status};
                if (cur.fixed)
                begin
                    void'(predict_status(cur));
                    pending_status_q.push_back(cur.fixed_status);
                end
                else
                    pending_status_q.push_back(predict_status(cur));
            end
            if (in_valid && in_stall)
                ;
            else if (cmd_q.size() > 0 && $urandom_range(99) >= snd_idle_pct)
            begin
                cur = cmd_q.pop_front();
                mode <= cur.mode;
                duration_us <= cur.duration_us;
                last_entry <= cur.last_entry;
                abort_req <= cur.abort_req;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Status side: check each transfer, stall at random or for a long hold
    always @(posedge clk)
    begin : receiver
        ir_status_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_status_q.size() == 0)
                begin
                    $error("status transfer with no expected status");
                    mismatches++;
                end
                else
                begin
                    want = pending_status_q.pop_front();
                    check_field("pin_level", want.pin_level, pin_level);
                    check_field("need_entry", want.need_entry, need_entry);
                    check_field("frame_done", want.frame_done, frame_done);
                    check_field("load_rejected", want.load_rejected, load_rejected);
                end
            end
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < rcv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("ir_mark_space_carrier_transmitter_unit: mismatch");
            $finish;
        end
    end

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_CARRIER_ON:  carrier_on_cfg = value;
            CFG_CARRIER_OFF: carrier_off_cfg = value;
            CFG_ACTIVE_HIGH: pol_high = value[0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (cmd_q.size() > 0 || in_valid || pending_status_q.size() > 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Mostly well-formed frames with random lengths, plus aborts,
    // loads into a running entry and ticks between entries
    task automatic queue_random_frames(input int count);
        ir_cmd_t c;
        int      pick;
        for (int n = 0; n < count; n++)
        begin
            c = '0;
            c.duration_us = DUR_W'($urandom);
            c.last_entry = 1'($urandom_range(1));
            pick = $urandom_range(99);
            if (gen_left > 0)
            begin
                if (pick < ((gen_left > 300) ? 5 : 1))
                begin
                    c.mode = 1'($urandom_range(1));
                    c.abort_req = 1'b1;
                    gen_left = 0;
                end
                else if (pick < 6)
                    c.mode = MODE_LOAD;
                else
                begin
                    c.mode = MODE_TICK;
                    gen_left--;
                end
            end
            else if (pick < 4)
            begin
                c.mode = 1'($urandom_range(1));
                c.abort_req = 1'b1;
            end
            else if (pick < 12)
                c.mode = MODE_TICK;
            else
            begin
                c.mode = MODE_LOAD;
                c.last_entry = ($urandom_range(99) < 20);
                pick = $urandom_range(99);
                if (pick < 80)
                    c.duration_us = DUR_W'($urandom_range(40));
                else if (pick < 95)
                    c.duration_us = DUR_W'($urandom_range(300, 41));
                gen_left = int'(c.duration_us);
            end
            cmd_q.push_back(c);
        end
    endtask

    initial
    begin : run
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[i])
            cmd_q.push_back(DIRECTED[i]);
        gen_left = DIRECTED_TAIL;

        foreach (PLAN[p])
        begin
            wait_drained();
            write_reg(CFG_CARRIER_ON, PLAN[p].on_us);
            write_reg(CFG_CARRIER_OFF, PLAN[p].off_us);
            write_reg(CFG_ACTIVE_HIGH,
                      (CFG_DATA_W'($urandom_range(2047)) << 1) | CFG_DATA_W'(PLAN[p].hi));
            snd_idle_pct = int'(PLAN[p].snd_pct);
            rcv_idle_pct = int'(PLAN[p].rcv_pct);
            if (PLAN[p].hold)
                hold_requests++;
            queue_random_frames(int'(PLAN[p].n_items));
        end

        wait_drained();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("ir_mark_space_carrier_transmitter_unit: match");
        else
            $display("ir_mark_space_carrier_transmitter_unit: mismatch");
        $finish;
    end

endmodule

// File: files.f
src/irmsct_pkg.sv
src/ir_mark_space_carrier_transmitter_unit.sv
test/tb_ir_mark_space_carrier_transmitter_unit.sv
